[sv/assert_macros.svh]
// assertion helpers included by shared_array_multi_stack
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is low
`define SAMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication check on the rising clock edge, off while reset is low
`define SAMS_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

[sv/sams_pkg.sv]
// ----------------------------------------------------------------------------
// sams_pkg
// shared constants and codes of the multi stack store
// ----------------------------------------------------------------------------
`default_nettype none

package sams_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int NSTACKS_DEF = 4;
    localparam int DW_DEF      = 32;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_COUNT  = 2'd2;
    localparam logic [1:0] KIND_SEARCH = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADSTK = 2'd1;
    localparam logic [1:0] ST_FAIL   = 2'd2;

endpackage

`default_nettype wire

[sv/sams_if.sv]
// ----------------------------------------------------------------------------
// sams_in_if / sams_out_if
// valid/ready channels carrying requests and results
// ----------------------------------------------------------------------------
`default_nettype none

interface sams_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [2:0]         stack_sel;
    logic signed [31:0] value;
    modport source (output valid, kind, stack_sel, value, input ready);
    modport sink   (input valid, kind, stack_sel, value, output ready);
endinterface

interface sams_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [4:0]         count;
    logic [2:0]         found_stack;
    modport source (output valid, status, data, count, found_stack, input ready);
    modport sink   (input valid, status, data, count, found_stack, output ready);
endinterface

`default_nettype wire

[sv/shared_array_multi_stack.sv]
// ----------------------------------------------------------------------------
// shared_array_multi_stack
// several stacks living in one word store, walked by a small sequencer
// ----------------------------------------------------------------------------
// NSTACKS stacks share one store of DEPTH words. Every item is a push, pop,
// count or search and gives exactly one result item. All store traffic goes
// through a single memory port (one access per cycle, registered read data).
// A push into a full stack first slides later stacks right and then maybe
// itself left, one word at a time with a read and then a write per word. A
// search reads each stored word in stack order until it finds a match. A new
// item is taken only while the sequencer is idle; a finished result sits in
// an output register until taken. Store words outside any stack are never
// read, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module shared_array_multi_stack #(
    parameter int DEPTH      = sams_pkg::DEPTH_DEF,
    parameter int NSTACKS    = sams_pkg::NSTACKS_DEF,
    parameter int DATA_WIDTH = sams_pkg::DW_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sams_in_if.sink     i_in,
    sams_out_if.source  o_out
);

    localparam int SLICE = DEPTH / NSTACKS;
    localparam int AW    = $clog2(DEPTH);
    // tops point one past the last word; positions range 0 .. DEPTH
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int XW    = $clog2(NSTACKS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_POP  = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_SCMP = 4'd4;
    localparam logic [3:0] S_MR   = 4'd5;
    localparam logic [3:0] S_MRR  = 4'd6;
    localparam logic [3:0] S_MRW  = 4'd7;
    localparam logic [3:0] S_ML   = 4'd8;
    localparam logic [3:0] S_MLR  = 4'd9;
    localparam logic [3:0] S_MLW  = 4'd10;
    localparam logic [3:0] S_PUSH = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    // sequencer state and latched item
    logic [3:0]            r_state;
    logic [1:0]            r_kind;
    logic [XW-1:0]         r_sel;
    logic                  r_bad;
    logic [DATA_WIDTH-1:0] r_val;
    logic [XW-1:0]         r_idx;
    logic [CW-1:0]         r_p;

    // tops and bases, entry NSTACKS is the fixed boundary
    logic [CW-1:0]         r_t [NSTACKS+1];
    logic [CW-1:0]         r_b [NSTACKS+1];

    // word store
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic                  we;
    logic [AW-1:0]         wa;
    logic [AW-1:0]         ra;
    logic [DATA_WIDTH-1:0] wd;

    // pending result and output register
    logic [1:0]            r_st;
    logic [DATA_WIDTH-1:0] r_dat;
    logic [4:0]            r_cnt;
    logic [2:0]            r_fnd;
    logic                  r_ovalid;
    logic [1:0]            r_ost;
    logic [31:0]           r_odat;
    logic [4:0]            r_ocnt;
    logic [2:0]            r_ofnd;

    logic [63:0]           in_wide;
    logic [63:0]           dat_wide;
    logic                  sel_ok;
    logic                  full_s;
    logic                  full_sm1;
    logic                  full_idx;
    logic [XW-1:0]         sel_p1;
    logic [XW-1:0]         sel_m1;
    logic [XW-1:0]         idx_p1;

    assign in_wide  = {32'd0, $unsigned(i_in.value)};
    assign dat_wide = 64'(r_dat);
    assign sel_ok   = {1'b0, i_in.stack_sel} < 4'(NSTACKS);
    assign sel_p1   = XW'(r_sel + 1'b1);
    assign sel_m1   = XW'(r_sel - 1'b1);
    assign idx_p1   = XW'(r_idx + 1'b1);
    // a stack is full when its top meets the next base
    assign full_s   = r_t[r_sel] == r_b[sel_p1];
    assign full_sm1 = r_t[sel_m1] == r_b[r_sel];
    assign full_idx = r_t[r_idx] == r_b[idx_p1];

    assign i_in.ready        = r_state == S_IDLE;
    assign o_out.valid       = r_ovalid;
    assign o_out.status      = r_ost;
    assign o_out.data        = $signed(r_odat);
    assign o_out.count       = r_ocnt;
    assign o_out.found_stack = r_ofnd;

    // memory port control
    always_comb begin
        we = 1'b0;
        wa = AW'(r_p);
        wd = r_rdata;
        ra = AW'(r_p);
        unique case (r_state)
            S_DEC:   ra = AW'(r_t[r_sel] - 1'b1);
            S_MRR:   ra = AW'(r_p - 1'b1);
            S_MRW:   we = 1'b1;
            S_MLW: begin
                we = 1'b1;
                wa = AW'(r_p - 1'b1);
            end
            S_PUSH: begin
                we = 1'b1;
                wa = AW'(r_t[r_sel]);
                wd = r_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rdata <= mem[ra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i <= NSTACKS; i++) begin
                r_t[i] <= CW'(i * SLICE);
                r_b[i] <= CW'(i * SLICE);
            end
        end else begin
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_kind  <= i_in.kind;
                        r_sel   <= XW'(i_in.stack_sel);
                        r_bad   <= !sel_ok;
                        r_val   <= in_wide[DATA_WIDTH-1:0];
                        r_st    <= sams_pkg::ST_OK;
                        r_dat   <= '0;
                        r_cnt   <= '0;
                        r_fnd   <= '0;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_kind == sams_pkg::KIND_SEARCH) begin
                        r_idx   <= '0;
                        r_p     <= r_b[0];
                        r_state <= S_SCAN;
                    end else if (r_bad) begin
                        r_st    <= sams_pkg::ST_BADSTK;
                        r_state <= S_OUT;
                    end else if (r_kind == sams_pkg::KIND_POP) begin
                        if (r_t[r_sel] != r_b[r_sel]) begin
                            r_state <= S_POP;
                        end else begin
                            r_st    <= sams_pkg::ST_FAIL;
                            r_state <= S_OUT;
                        end
                    end else if (r_kind == sams_pkg::KIND_COUNT) begin
                        r_cnt   <= 5'(r_t[r_sel] - r_b[r_sel]);
                        r_state <= S_OUT;
                    end else if (!full_s) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_idx   <= XW'(NSTACKS - 1);
                        r_state <= S_MR;
                    end
                end
                S_POP: begin
                    r_dat      <= r_rdata;
                    r_t[r_sel] <= r_t[r_sel] - 1'b1;
                    r_state    <= S_OUT;
                end
                // search: stacks in order, words in each
                S_SCAN: begin
                    if (r_idx == XW'(NSTACKS)) begin
                        r_st    <= sams_pkg::ST_FAIL;
                        r_state <= S_OUT;
                    end else if (r_p == r_t[r_idx]) begin
                        r_idx <= idx_p1;
                        r_p   <= r_b[idx_p1];
                    end else begin
                        r_state <= S_SCMP;
                    end
                end
                S_SCMP: begin
                    if (r_rdata == r_val) begin
                        r_fnd   <= 3'(r_idx);
                        r_state <= S_OUT;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                // slide later stacks right, last one first
                S_MR: begin
                    if (r_idx == r_sel) begin
                        r_state <= S_ML;
                    end else if (full_idx) begin
                        r_idx <= r_idx - 1'b1;
                    end else begin
                        r_p     <= r_t[r_idx];
                        r_state <= S_MRR;
                    end
                end
                S_MRR: begin
                    if (r_p == r_b[r_idx]) begin
                        r_t[r_idx] <= r_t[r_idx] + 1'b1;
                        r_b[r_idx] <= r_b[r_idx] + 1'b1;
                        r_idx      <= r_idx - 1'b1;
                        r_state    <= S_MR;
                    end else begin
                        r_state <= S_MRW;
                    end
                end
                S_MRW: begin
                    r_p     <= r_p - 1'b1;
                    r_state <= S_MRR;
                end
                // still full: slide this stack left if the one below has room
                S_ML: begin
                    if (!full_s) begin
                        r_state <= S_PUSH;
                    end else if (r_sel != '0 && !full_sm1) begin
                        r_p     <= r_b[r_sel];
                        r_state <= S_MLR;
                    end else begin
                        r_st    <= sams_pkg::ST_FAIL;
                        r_state <= S_OUT;
                    end
                end
                S_MLR: begin
                    if (r_p == r_t[r_sel]) begin
                        r_t[r_sel] <= r_t[r_sel] - 1'b1;
                        r_b[r_sel] <= r_b[r_sel] - 1'b1;
                        r_state    <= S_PUSH;
                    end else begin
                        r_state <= S_MLW;
                    end
                end
                S_MLW: begin
                    r_p     <= r_p + 1'b1;
                    r_state <= S_MLR;
                end
                S_PUSH: begin
                    r_t[r_sel] <= r_t[r_sel] + 1'b1;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_ost    <= r_st;
                        r_odat   <= dat_wide[31:0];
                        r_ocnt   <= r_cnt;
                        r_ofnd   <= r_fnd;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // stack 0 never moves and the boundary is fixed
    `SAMS_ASSERT(a_fixed_ends, (r_b[0] == '0 && r_b[NSTACKS] == CW'(NSTACKS * SLICE)), "base moved")
    // a search never reports a bad stack index
    `SAMS_ASSERT_IMP(a_search_st, (r_state == S_OUT && r_kind == sams_pkg::KIND_SEARCH), (r_st != sams_pkg::ST_BADSTK), "bad status on search")
    // a new result only comes out of the result state
    `SAMS_ASSERT_IMP(a_out_src, $rose(r_ovalid), ($past(r_state) == S_OUT), "result out of sequence")

endmodule

`default_nettype wire
